// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Implication checked at every rising clock edge while reset is released.
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

`endif

// File: sv/diodf_pkg.sv
// Package with the constants and types of the on/off delay input filter.
package diodf_pkg;

  localparam int unsigned CHANNELS = 16;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ON_DELAY = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFF_DELAY = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] on_delay;
    logic [TICK_W-1:0] off_delay;
  } delay_cfg_t;

endpackage

// File: sv/diodf_lane.sv
// One channel of the filter: mode, on and off timers and the previous level.
module diodf_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 enable_i,
  input  logic                 raw_i,
  input  diodf_pkg::delay_cfg_t dly_i,
  output logic                 level_o
);

  typedef enum logic [1:0] {
    MODE_NEUTRAL   = 2'd1,
    MODE_DELAY_ON  = 2'd2,
    MODE_DELAY_OFF = 2'd3
  } mode_e;

  mode_e                          mode_q, mode_d;
  logic [diodf_pkg::TICK_W-1:0]   on_q, on_d;
  logic [diodf_pkg::TICK_W-1:0]   off_q, off_d;
  logic                           last_q;
  logic                           filt;
  logic                           rise;
  logic                           fall;
  logic                           on_nz;
  logic                           off_nz;

  assign rise   = raw_i & ~last_q;
  assign fall   = ~raw_i & last_q;
  assign on_nz  = (on_q != '0);
  assign off_nz = (off_q != '0);

  always_comb begin
    filt   = raw_i;
    mode_d = mode_q;
    on_d   = on_q;
    off_d  = off_q;
    if (rise) begin
      unique case (mode_q)
        MODE_NEUTRAL: begin
          on_d   = dly_i.on_delay;
          filt   = 1'b0;
          mode_d = MODE_DELAY_ON;
        end
        MODE_DELAY_ON: begin
          on_d = dly_i.on_delay;
          filt = 1'b0;
        end
        MODE_DELAY_OFF: begin
          if (off_nz) begin
            off_d = off_q - 1'b1;
          end else begin
            mode_d = MODE_NEUTRAL;
          end
        end
        default: begin
          filt = raw_i;
        end
      endcase
    end else if (fall) begin
      unique case (mode_q)
        MODE_NEUTRAL: begin
          off_d  = dly_i.off_delay;
          filt   = 1'b1;
          mode_d = MODE_DELAY_OFF;
        end
        MODE_DELAY_ON: begin
          if (on_nz) begin
            on_d = on_q - 1'b1;
          end else begin
            mode_d = MODE_NEUTRAL;
            filt   = 1'b1;
          end
        end
        MODE_DELAY_OFF: begin
          off_d = dly_i.off_delay;
          filt  = 1'b1;
        end
        default: begin
          filt = raw_i;
        end
      endcase
    end else begin
      unique case (mode_q)
        MODE_DELAY_ON: begin
          if (on_nz) begin
            on_d = on_q - 1'b1;
            filt = 1'b0;
          end else begin
            mode_d = MODE_NEUTRAL;
          end
        end
        MODE_DELAY_OFF: begin
          if (off_nz) begin
            off_d = off_q - 1'b1;
            filt  = 1'b1;
          end else begin
            mode_d = MODE_NEUTRAL;
          end
        end
        default: begin
          filt = raw_i;
        end
      endcase
    end
  end

  assign level_o = enable_i ? filt : raw_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NEUTRAL;
      on_q   <= '0;
      off_q  <= '0;
      last_q <= 1'b0;
    end else if (step_i && enable_i) begin
      mode_q <= mode_d;
      on_q   <= on_d;
      off_q  <= off_d;
      last_q <= raw_i;
    end
  end

endmodule

// File: sv/diodf_merge.sv
// Output stage that gathers the lane levels into one word and holds it.
module diodf_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [diodf_pkg::CHANNELS-1:0] levels_i,
  input  logic                         out_ready_i,
  output logic                         ready_o,
  output logic                         out_valid_o,
  output logic [diodf_pkg::WORD_W-1:0] word_o
);

  logic                         valid_q;
  logic [diodf_pkg::WORD_W-1:0] word_q;
  logic                         load;

  assign ready_o = !valid_q || out_ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= diodf_pkg::WORD_W'(levels_i);
    end
  end

  assign out_valid_o = valid_q;
  assign word_o      = word_q;

endmodule

// File: sv/digital_input_on_off_delay_filter_top.sv
// Top level of the on/off delay filter for a word of digital inputs.
// One request holds one raw word and gives one filtered word. The block takes a
// request every cycle: the enabled channel lanes update their state in the cycle
// the request is accepted, and the filtered word appears in the output register
// in the next cycle. A new request is taken whenever that register is empty or
// is being drained in the same cycle, so the sustained rate is one word per cycle.
module digital_input_on_off_delay_filter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [diodf_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [diodf_pkg::TICK_W-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [diodf_pkg::WORD_W-1:0]     raw_bits_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [diodf_pkg::WORD_W-1:0]     filtered_bits_o
);

  logic [diodf_pkg::CHANNELS-1:0] enable_q;
  diodf_pkg::delay_cfg_t          dly_q;
  logic [diodf_pkg::CHANNELS-1:0] levels;
  logic                           step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      dly_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        diodf_pkg::REG_ENABLE_MASK: enable_q <= diodf_pkg::CHANNELS'(cfg_data_i);
        diodf_pkg::REG_ON_DELAY:    dly_q.on_delay <= cfg_data_i;
        diodf_pkg::REG_OFF_DELAY:   dly_q.off_delay <= cfg_data_i;
        default: begin
          enable_q <= enable_q;
        end
      endcase
    end
  end

  assign step = in_valid_i && in_ready_o;

  for (genvar g = 0; g < diodf_pkg::CHANNELS; g++) begin : g_lane
    diodf_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (step),
      .enable_i (enable_q[g]),
      .raw_i    (raw_bits_i[g]),
      .dly_i    (dly_q),
      .level_o  (levels[g])
    );
  end

  diodf_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .levels_i    (levels),
    .out_ready_i (out_ready_i),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .word_o      (filtered_bits_o)
  );

endmodule

// File: sv/diodf_checker.sv
// Port checker for the on/off delay filter, bound to the top level.
`include "assert_macros.svh"

module diodf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [diodf_pkg::WORD_W-1:0]     filtered_bits_o
);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
  `ASSERT_CLK(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(filtered_bits_o))
  `ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `ASSERT_CLK(a_result_follows, clk_i, rst_ni, in_valid_i && in_ready_o |=> out_valid_o)

endmodule

bind digital_input_on_off_delay_filter_top diodf_checker u_diodf_checker (.*);

// File: tb/tb_digital_input_on_off_delay_filter_top.sv
// Self-checking testbench for the on/off delay digital input filter top level.
module tb_digital_input_on_off_delay_filter_top;

  typedef enum logic [1:0] {
    CM_NONE      = 2'd0,
    CM_NEUTRAL   = 2'd1,
    CM_DELAY_ON  = 2'd2,
    CM_DELAY_OFF = 2'd3
  } chan_mode_e;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;
  typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_e;

  typedef struct packed {
    row_kind_e                       kind;
    logic [diodf_pkg::REG_IDX_W-1:0] idx;
    logic [diodf_pkg::WORD_W-1:0]    val;
    logic                            typed;
    logic [diodf_pkg::WORD_W-1:0]    typed_word;
  } row_t;

  localparam logic [diodf_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int NUM_PHASES = 9;
  localparam int WORDS_PER_PHASE = 48;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DIR_ROWS = 27;

  localparam row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'h0000, 1'b1, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'hFFFF, 1'b1, 16'hFFFF},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'hA5A5, 1'b1, 16'hA5A5},
    '{ROW_CFG,  REG_UNUSED,                 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'h5A5A, 1'b1, 16'h5A5A},
    '{ROW_CFG,  diodf_pkg::REG_ENABLE_MASK, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_CFG,  diodf_pkg::REG_ON_DELAY,    16'h0001, 1'b0, 16'h0000},
    '{ROW_CFG,  diodf_pkg::REG_OFF_DELAY,   16'h0001, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_CFG,  diodf_pkg::REG_ON_DELAY,    16'hFFFF, 1'b0, 16'h0000},
    '{ROW_CFG,  diodf_pkg::REG_OFF_DELAY,   16'h0000, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WORD, diodf_pkg::REG_ENABLE_MASK, 16'hFFFF, 1'b0, 16'h0000}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [diodf_pkg::REG_IDX_W-1:0] cfg_idx_i = '0;
  logic [diodf_pkg::TICK_W-1:0]    cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [diodf_pkg::WORD_W-1:0]    raw_bits_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [diodf_pkg::WORD_W-1:0]    filtered_bits_o;

  chan_mode_e                   chan_mode [diodf_pkg::CHANNELS];
  logic [diodf_pkg::TICK_W-1:0] on_count [diodf_pkg::CHANNELS];
  logic [diodf_pkg::TICK_W-1:0] off_count [diodf_pkg::CHANNELS];
  logic                         prev_level [diodf_pkg::CHANNELS];
  logic [diodf_pkg::WORD_W-1:0] en_mask = '0;
  logic [diodf_pkg::TICK_W-1:0] on_ticks = '0;
  logic [diodf_pkg::TICK_W-1:0] off_ticks = '0;

  logic [diodf_pkg::WORD_W-1:0] filtered_due_q [$];
  logic [diodf_pkg::WORD_W-1:0] due_word;
  int unsigned       err_cnt = 0;
  int unsigned       words_sent = 0;
  int unsigned       words_checked = 0;
  int unsigned       settings_used = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       burst_left = 0;
  logic              sender_idles = 1'b1;
  ready_mode_e       ready_mode = READY_RANDOM;
  logic [7:0]        stall_pat = 8'hB6;
  logic [2:0]        pat_pos = '0;

  digital_input_on_off_delay_filter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .raw_bits_i      (raw_bits_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .filtered_bits_o (filtered_bits_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [diodf_pkg::WORD_W-1:0] filter_word(
    input logic [diodf_pkg::WORD_W-1:0] raw);
    logic [diodf_pkg::WORD_W-1:0] word;
    logic                         lvl;
    word = raw;
    for (int ch = 0; ch < diodf_pkg::CHANNELS; ch++) begin
      if (en_mask[ch]) begin
        lvl = raw[ch];
        if (raw[ch] && !prev_level[ch]) begin
          case (chan_mode[ch])
            CM_NEUTRAL: begin
              on_count[ch] = on_ticks;
              lvl = 1'b0;
              chan_mode[ch] = CM_DELAY_ON;
            end
            CM_DELAY_ON: begin
              on_count[ch] = on_ticks;
              lvl = 1'b0;
            end
            CM_DELAY_OFF: begin
              if (off_count[ch] != 0) off_count[ch] = off_count[ch] - 1'b1;
              else chan_mode[ch] = CM_NEUTRAL;
            end
            default: ;
          endcase
        end else if (!raw[ch] && prev_level[ch]) begin
          case (chan_mode[ch])
            CM_NEUTRAL: begin
              off_count[ch] = off_ticks;
              lvl = 1'b1;
              chan_mode[ch] = CM_DELAY_OFF;
            end
            CM_DELAY_ON: begin
              if (on_count[ch] != 0) begin
                on_count[ch] = on_count[ch] - 1'b1;
              end else begin
                chan_mode[ch] = CM_NEUTRAL;
                lvl = 1'b1;
              end
            end
            CM_DELAY_OFF: begin
              off_count[ch] = off_ticks;
              lvl = 1'b1;
            end
            default: ;
          endcase
        end else begin
          case (chan_mode[ch])
            CM_DELAY_ON: begin
              if (on_count[ch] != 0) begin
                on_count[ch] = on_count[ch] - 1'b1;
                lvl = 1'b0;
              end else begin
                chan_mode[ch] = CM_NEUTRAL;
              end
            end
            CM_DELAY_OFF: begin
              if (off_count[ch] != 0) begin
                off_count[ch] = off_count[ch] - 1'b1;
                lvl = 1'b1;
              end else begin
                chan_mode[ch] = CM_NEUTRAL;
              end
            end
            default: ;
          endcase
        end
        prev_level[ch] = raw[ch];
        word[ch] = lvl;
      end
    end
    return word;
  endfunction

  // Called at a falling edge; the block is drained before any register changes.
  task automatic cfg_write(input logic [diodf_pkg::REG_IDX_W-1:0] idx,
                           input logic [diodf_pkg::TICK_W-1:0] data);
    in_valid_i <= 1'b0;
    while (filtered_due_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      diodf_pkg::REG_ENABLE_MASK: en_mask = data;
      diodf_pkg::REG_ON_DELAY:    on_ticks = data;
      diodf_pkg::REG_OFF_DELAY:   off_ticks = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_word(input logic [diodf_pkg::WORD_W-1:0] raw, input logic typed,
                           input logic [diodf_pkg::WORD_W-1:0] typed_word);
    logic [diodf_pkg::WORD_W-1:0] predicted;
    if (sender_idles && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i <= 1'b1;
    raw_bits_i <= raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = filter_word(raw);
    filtered_due_q.push_back(typed ? typed_word : predicted);
    words_sent++;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    case (ready_mode)
      READY_ALWAYS: out_ready_i <= 1'b1;
      READY_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
      default:      out_ready_i <= stall_pat[pat_pos];
    endcase
    pat_pos <= pat_pos + 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filtered_due_q.size() == 0) begin
        $error("filtered_bits: no request pending, got %h", filtered_bits_o);
        err_cnt++;
      end else begin
        due_word = filtered_due_q.pop_front();
        words_checked++;
        if (filtered_bits_o !== due_word) begin
          $error("filtered_bits: expected %h, actual %h", due_word, filtered_bits_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[digital_input_on_off_delay_filter_top] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [diodf_pkg::WORD_W-1:0] cur_raw;
    logic [diodf_pkg::TICK_W-1:0] new_en;
    logic [diodf_pkg::TICK_W-1:0] new_on;
    logic [diodf_pkg::TICK_W-1:0] new_off;
    int unsigned                  pick;
    for (int ch = 0; ch < diodf_pkg::CHANNELS; ch++) begin
      chan_mode[ch] = CM_NEUTRAL;
      on_count[ch] = '0;
      off_count[ch] = '0;
      prev_level[ch] = 1'b0;
    end
    cur_raw = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    settings_used = 2;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) cfg_write(DIRECTED[r].idx, DIRECTED[r].val);
      else send_word(DIRECTED[r].val, DIRECTED[r].typed, DIRECTED[r].typed_word);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          new_en = 16'hFFFF;
          new_on = 16'h0000;
          new_off = 16'h0000;
        end
        1: begin
          new_en = 16'hFFFF;
          new_on = 16'hFFFF;
          new_off = 16'hFFFF;
        end
        2: begin
          new_en = 16'h0000;
          new_on = 16'($urandom_range(0, 6));
          new_off = 16'($urandom_range(0, 6));
        end
        default: begin
          new_en = 16'($urandom);
          new_on = 16'($urandom_range(0, 6));
          new_off = 16'($urandom_range(0, 6));
        end
      endcase
      sender_idles = (phase % 4 != 3);
      ready_mode = ready_mode_e'(phase % 3);
      stall_pat = 8'($urandom_range(1, 255));
      cfg_write(diodf_pkg::REG_ENABLE_MASK, new_en);
      cfg_write(diodf_pkg::REG_ON_DELAY, new_on);
      cfg_write(diodf_pkg::REG_OFF_DELAY, new_off);
      cfg_write(REG_UNUSED, 16'($urandom));
      settings_used++;

      // Mostly sparse edges so the timers get to run out, with some noise words.
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) cur_raw = cur_raw ^ 16'($urandom & $urandom & $urandom);
        else if (pick >= 8) cur_raw = 16'($urandom);
        send_word(cur_raw, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (filtered_due_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);

    $display("Sent %0d raw words under %0d register settings, %0d filtered words compared.",
             words_sent, settings_used, words_checked);
    if (err_cnt == 0) begin
      $display("[digital_input_on_off_delay_filter_top] OK");
    end else begin
      $display("[digital_input_on_off_delay_filter_top] ERROR");
    end
    $finish;
  end

endmodule
